// ===== src/trm_pkg.sv =====
package trm_pkg;

  // Field widths
  localparam int TICK_W = 16;
  localparam int RES_W  = 16;

  // Midpoint times five fits in 19 bits
  localparam int MID_W = 19;

  // Revolutions-per-second numerator
  localparam int          NUM_W   = 20;
  localparam logic [19:0] RPS_NUM = 20'd1000000;

  // rpm = rps * 60
  localparam int         RPM_MUL_W  = 6;
  localparam logic [5:0] SEC_PER_MIN = 6'd60;

  localparam logic [15:0] MIN_RESET = 16'hFFFF;

  // Parameter defaults
  localparam int TICK_SCALE_DEF    = 4;
  localparam int PULSE_DIVISOR_DEF = 1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_PROD,
    ST_PULSE,
    ST_CHK,
    ST_DIV,
    ST_WAIT,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic pulse_upd;   // fold an interval into min/max
    logic capture;     // latch window, restart min/max
    logic mid_en;
    logic prod_en;
    logic pt_en;       // latch pulse time
    logic zero_chk;    // latch zero revolution time
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic none;
    logic qzero;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== src/tacho_interval_rpm_meter_top.sv =====
// Pulse words: one per cycle while the controller is idle, no result,
// folded into the window min/max. End-of-window word: result after the
// one-bit-per-cycle 20-step rps division, skipped on zero revolution time
// or no pulse. Input stalls until the controller is idle again.
// Synchronous active-low reset: controller idle, no result pending,
// max interval 0, min interval 65535.
module tacho_interval_rpm_meter_top #(
  parameter int TICK_SCALE    = trm_pkg::TICK_SCALE_DEF,
  parameter int PULSE_DIVISOR = trm_pkg::PULSE_DIVISOR_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [trm_pkg::TICK_W-1:0] in_interval_ticks,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [trm_pkg::RES_W-1:0]  out_speed_rpm,
  output logic [trm_pkg::RES_W-1:0]  out_speed_rps,
  output logic                       out_no_pulses,
  output logic                       out_zero_period
);

  import trm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  trm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  trm_dp #(
    .TICK_SCALE    (TICK_SCALE),
    .PULSE_DIVISOR (PULSE_DIVISOR)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_interval_ticks (in_interval_ticks),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_speed_rpm     (out_speed_rpm),
    .out_speed_rps     (out_speed_rps),
    .out_no_pulses     (out_no_pulses),
    .out_zero_period   (out_zero_period)
  );

endmodule

// ===== src/trm_div.sv =====
module trm_div #(
  parameter int DIV_W = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DIV_W-1:0]           dividend,   // left aligned
  input  logic [DIV_W-1:0]           divisor,
  input  logic [$clog2(DIV_W+1)-1:0] nbits,
  output logic [DIV_W-1:0]           quotient,
  output logic                       done
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic             ge;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    ge      = ~diff[DIV_W];
    rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== src/trm_dp.sv =====
module trm_dp #(
  parameter int TICK_SCALE    = trm_pkg::TICK_SCALE_DEF,
  parameter int PULSE_DIVISOR = trm_pkg::PULSE_DIVISOR_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  trm_pkg::dp_cmd_t            cmd,
  output trm_pkg::dp_stat_t           stat,
  input  logic [trm_pkg::TICK_W-1:0]  in_interval_ticks,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [trm_pkg::RES_W-1:0]   out_speed_rpm,
  output logic [trm_pkg::RES_W-1:0]   out_speed_rps,
  output logic                        out_no_pulses,
  output logic                        out_zero_period
);

  import trm_pkg::*;

  localparam int TS_W    = $clog2(TICK_SCALE + 1);
  localparam int PROD_W  = MID_W + TS_W;
  localparam int DIV_W   = (PROD_W + 1 > NUM_W) ? PROD_W + 1 : NUM_W;
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int DVR_EFF = (PULSE_DIVISOR == 0) ? 1 : PULSE_DIVISOR;
  localparam int RPM_W   = RES_W + RPM_MUL_W;

  // Pulse time by reciprocal: floor(p / d) = (p * M) >> SH, exact for p < 2^PROD_W
  localparam int              RCP_L  = $clog2(DVR_EFF);
  localparam int              RCP_SH = PROD_W + RCP_L;
  localparam int              RCP_W  = PROD_W + 1;
  localparam longint unsigned RCP_M  =
    ((64'd1 << RCP_SH) + 64'(DVR_EFF) - 64'd1) / 64'(DVR_EFF);
  localparam int              PT_W   = PROD_W + RCP_W;

  logic [TICK_W-1:0] max_r;
  logic [TICK_W-1:0] min_r;
  logic [TICK_W:0]   sum_r;
  logic              none_r;
  logic              zero_r;
  logic [MID_W-1:0]  mid_r;
  logic [PROD_W-1:0] prod_r;
  logic [TICK_W-1:0] half;
  logic [PT_W-1:0]   pt_full;
  logic [PROD_W-1:0] pt_r;

  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic [DIV_W-1:0]  quo;
  logic              div_done;

  logic              out_valid_r;
  logic [RES_W-1:0]  rpm_r;
  logic [RES_W-1:0]  rps_r;
  logic              no_pulses_r;
  logic              zero_period_r;
  logic [RES_W-1:0]  rps;
  logic [RPM_W-1:0]  rpm_full;

  // Window min/max tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
      min_r <= MIN_RESET;
    end else if (cmd.capture) begin
      max_r <= '0;
      min_r <= MIN_RESET;
    end else if (cmd.pulse_upd) begin
      if (in_interval_ticks > max_r) begin
        max_r <= in_interval_ticks;
      end
      if (in_interval_ticks < min_r) begin
        min_r <= in_interval_ticks;
      end
    end
  end

  // Window snapshot and flags
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sum_r  <= {1'b0, max_r} + {1'b0, min_r};
      none_r <= max_r < min_r;
      zero_r <= 1'b0;
    end else if (cmd.zero_chk) begin
      zero_r <= (pt_r == '0);
    end
  end

  // Midpoint times five, then tick scale, then pulse divisor
  assign half    = sum_r[TICK_W:1];
  assign pt_full = PT_W'(prod_r) * PT_W'(RCP_M);

  always_ff @(posedge clk) begin
    if (cmd.mid_en) begin
      mid_r <= {1'b0, half, 2'b00} + {3'b000, half};
    end
    if (cmd.prod_en) begin
      prod_r <= PROD_W'(mid_r) * PROD_W'(TICK_SCALE);
    end
    if (cmd.pt_en) begin
      pt_r <= PROD_W'(pt_full >> RCP_SH);
    end
  end

  // rps = 1000000 / (2 * pulse time)
  assign div_dividend = DIV_W'(RPS_NUM) << (DIV_W - NUM_W);
  assign div_divisor  = DIV_W'({pt_r, 1'b0});

  trm_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (CNT_W'(NUM_W)),
    .quotient (quo),
    .done     (div_done)
  );

  // Result word
  assign rps      = (none_r || zero_r) ? '0 : quo[RES_W-1:0];
  assign rpm_full = RPM_W'(rps) * RPM_W'(SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rps_r         <= rps;
      rpm_r         <= rpm_full[RES_W-1:0];
      no_pulses_r   <= none_r;
      zero_period_r <= zero_r && !none_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_speed_rpm   = rpm_r;
  assign out_speed_rps   = rps_r;
  assign out_no_pulses   = no_pulses_r;
  assign out_zero_period = zero_period_r;

  // Status
  assign stat.div_done = div_done;
  assign stat.none     = none_r;
  assign stat.qzero    = (pt_r == '0);
  assign stat.out_busy = out_valid_r;

endmodule

// ===== src/trm_ctrl.sv =====
module trm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_stall,
  input  trm_pkg::dp_stat_t  stat,
  output trm_pkg::dp_cmd_t   cmd
);

  import trm_pkg::*;

  state_t state_r, state_nxt;
  logic   in_acc;

  // End-of-window words wait for a free output register
  assign in_stall = (state_r != ST_IDLE) || (in_cmd && stat.out_busy);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_cmd) begin
          state_nxt = ST_MID;
        end
      end
      ST_MID: begin
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        state_nxt = stat.none ? ST_DONE : ST_PULSE;
      end
      ST_PULSE: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = stat.qzero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd           = '0;
    cmd.pulse_upd = in_acc && !in_cmd;
    cmd.capture   = in_acc && in_cmd;
    case (state_r)
      ST_MID: begin
        cmd.mid_en = 1'b1;
      end
      ST_PROD: begin
        cmd.prod_en = 1'b1;
      end
      ST_PULSE: begin
        cmd.pt_en = 1'b1;
      end
      ST_CHK: begin
        cmd.zero_chk = 1'b1;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/trm_tb_pkg.sv =====
`timescale 1ns / 100ps
package trm_tb_pkg;

  // Input word kinds
  typedef enum logic {
    CMD_PULSE      = 1'b0,
    CMD_WINDOW_END = 1'b1
  } tach_cmd_t;

endpackage

// ===== tb/rpm_window_checker.sv =====
`timescale 1ns / 100ps
module rpm_window_checker #(
  parameter int TICK_SCALE    = trm_pkg::TICK_SCALE_DEF,
  parameter int PULSE_DIVISOR = trm_pkg::PULSE_DIVISOR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_interval_ticks,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_speed_rpm,
  input  logic [15:0] out_speed_rps,
  input  logic        out_no_pulses,
  input  logic        out_zero_period,
  output int          fail_cnt,
  output int          outstanding,
  output int          checked_cnt
);

  localparam longint unsigned MID_FACTOR     = 5;
  localparam longint unsigned PULSES_PER_REV = 2;

  typedef struct packed {
    logic [15:0] rpm;
    logic [15:0] rps;
    logic        none;
    logic        zero;
  } rpm_word_t;

  // Results still owed by the block, oldest first
  rpm_word_t window_rpm_q[$];

  // Window extremes, mirrored from the block
  logic [15:0] max_iv;
  logic [15:0] min_iv;

  // Speed for a window closed with the given extremes
  function automatic rpm_word_t close_window(input logic [15:0] hi, input logic [15:0] lo);
    rpm_word_t       w;
    longint unsigned div_eff;
    longint unsigned mid;
    longint unsigned rev_time;
    longint unsigned quo;
    longint unsigned rpm_full;
    w = '0;
    div_eff = (PULSE_DIVISOR == 0) ? 1 : PULSE_DIVISOR;
    // max below min means nothing was folded in
    if (hi < lo) begin
      w.none = 1'b1;
      return w;
    end
    mid = MID_FACTOR * ((longint'(hi) + longint'(lo)) >> 1);
    rev_time = PULSES_PER_REV * ((mid * longint'(TICK_SCALE)) / div_eff);
    if (rev_time == 0) begin
      w.zero = 1'b1;
    end else begin
      quo = longint'(trm_pkg::RPS_NUM) / rev_time;
      w.rps = quo[15:0];
    end
    rpm_full = longint'(w.rps) * longint'(trm_pkg::SEC_PER_MIN);
    w.rpm = rpm_full[15:0];
    return w;
  endfunction

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin : watch
    rpm_word_t want;
    if (!rst_n) begin
      max_iv = 16'd0;
      min_iv = trm_pkg::MIN_RESET;
      window_rpm_q.delete();
      outstanding <= 0;
    end else begin
      // input side: fold pulses, predict on window end
      if (in_valid && !in_stall) begin
        if (in_cmd == trm_tb_pkg::CMD_WINDOW_END) begin
          window_rpm_q.push_back(close_window(max_iv, min_iv));
          max_iv = 16'd0;
          min_iv = trm_pkg::MIN_RESET;
        end else begin
          if (in_interval_ticks > max_iv) max_iv = in_interval_ticks;
          if (in_interval_ticks < min_iv) min_iv = in_interval_ticks;
        end
      end
      // result side: compare against oldest prediction
      if (out_valid && !out_stall) begin
        if (window_rpm_q.size() == 0) begin
          $error("unexpected result word: rpm %0d rps %0d no_pulses %0b zero_period %0b",
                 out_speed_rpm, out_speed_rps, out_no_pulses, out_zero_period);
          fail_cnt++;
        end else begin
          want = window_rpm_q.pop_front();
          check_field("speed_rpm", want.rpm, out_speed_rpm);
          check_field("speed_rps", want.rps, out_speed_rps);
          check_field("no_pulses", 16'(want.none), 16'(out_no_pulses));
          check_field("zero_period", 16'(want.zero), 16'(out_zero_period));
          checked_cnt++;
        end
      end
      outstanding <= window_rpm_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

  localparam int TICK_SCALE    = trm_pkg::TICK_SCALE_DEF;
  localparam int PULSE_DIVISOR = trm_pkg::PULSE_DIVISOR_DEF;
  localparam int N_ITEMS       = 1550;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 120;

  // How the intervals of one window are spread
  typedef enum int {
    SPREAD_ZERO_ONE,
    SPREAD_SMALL,
    SPREAD_MID,
    SPREAD_FULL,
    SPREAD_TOP,
    SPREAD_MIXED
  } spread_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_cmd = 1'b0;
  logic [15:0] in_interval_ticks = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] out_speed_rpm;
  logic [15:0] out_speed_rps;
  logic        out_no_pulses;
  logic        out_zero_period;

  int fail_cnt;
  int outstanding;
  int checked_cnt;
  int sent_pulses;
  int sent_closes;
  int burst_left;
  int idle_cycles;
  int stall_left;
  int stall_pick;
  logic stall_level = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  tacho_interval_rpm_meter_top #(
    .TICK_SCALE    (TICK_SCALE),
    .PULSE_DIVISOR (PULSE_DIVISOR)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_interval_ticks (in_interval_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_speed_rpm     (out_speed_rpm),
    .out_speed_rps     (out_speed_rps),
    .out_no_pulses     (out_no_pulses),
    .out_zero_period   (out_zero_period)
  );

  rpm_window_checker #(
    .TICK_SCALE    (TICK_SCALE),
    .PULSE_DIVISOR (PULSE_DIVISOR)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_interval_ticks (in_interval_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_speed_rpm     (out_speed_rpm),
    .out_speed_rps     (out_speed_rps),
    .out_no_pulses     (out_no_pulses),
    .out_zero_period   (out_zero_period),
    .fail_cnt          (fail_cnt),
    .outstanding       (outstanding),
    .checked_cnt       (checked_cnt)
  );

  // Receiver back-pressure: short bursts, rare long stalls, quiet stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(99);
      if (stall_pick < 10) begin
        stall_level = 1'b0;
        stall_left = $urandom_range(200, 600);
      end else if (stall_pick < 45) begin
        stall_level = 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (stall_pick < 90) begin
        stall_level = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        stall_level = 1'b1;
        stall_left = $urandom_range(20, 60);
      end
    end
    out_stall <= stall_level;
    stall_left = stall_left - 1;
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no handshake for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // One word, held until accepted, then a random gap
  task automatic send_word(input trm_tb_pkg::tach_cmd_t cmd, input logic [15:0] ticks);
    int gap;
    int pick;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_interval_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == trm_tb_pkg::CMD_PULSE) sent_pulses++;
    else sent_closes++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        burst_left = $urandom_range(50, 200);
        gap = 0;
      end else if (pick < 40) gap = 0;
      else if (pick < 88) gap = $urandom_range(1, 4);
      else if (pick < 97) gap = $urandom_range(5, 20);
      else gap = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_interval_ticks <= 16'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every predicted result has come out
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_ticks(input spread_t spread);
    case (spread)
      SPREAD_ZERO_ONE: return 16'($urandom_range(0, 1));
      SPREAD_SMALL:    return 16'($urandom_range(1, 40));
      SPREAD_MID:      return 16'($urandom_range(40, 3000));
      SPREAD_TOP:      return 16'($urandom_range(60000, 65535));
      default:         return 16'($urandom());
    endcase
  endfunction

  // n pulse words then the end-of-window word
  task automatic send_window(input int n_pulses, input spread_t spread);
    spread_t s;
    for (int i = 0; i < n_pulses; i++) begin
      s = (spread == SPREAD_MIXED) ? spread_t'($urandom_range(0, 4)) : spread;
      send_word(trm_tb_pkg::CMD_PULSE, pick_ticks(s));
    end
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'($urandom()));
  endtask

  initial begin
    int      pick;
    int      n_pulses;
    bit      paused;
    spread_t spread;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty window, zero revolution time, extremes
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'h0000);
    send_word(trm_tb_pkg::CMD_PULSE, 16'h0000);
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'h0000);
    send_word(trm_tb_pkg::CMD_PULSE, 16'h0000);
    send_word(trm_tb_pkg::CMD_PULSE, 16'h0001);
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'h0000);
    // fastest nonzero speed, rpm wraps
    send_word(trm_tb_pkg::CMD_PULSE, 16'h0001);
    send_word(trm_tb_pkg::CMD_PULSE, 16'h0001);
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'hFFFF);
    // slowest: quotient truncates to 0 without the zero flag
    send_word(trm_tb_pkg::CMD_PULSE, 16'hFFFF);
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'h0000);
    send_word(trm_tb_pkg::CMD_PULSE, 16'h0000);
    send_word(trm_tb_pkg::CMD_PULSE, 16'hFFFF);
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'hAAAA);
    send_word(trm_tb_pkg::CMD_PULSE, 16'hAAAA);
    send_word(trm_tb_pkg::CMD_PULSE, 16'h5555);
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'h5555);
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'hFFFF);
    send_word(trm_tb_pkg::CMD_PULSE, 16'd2);
    send_word(trm_tb_pkg::CMD_PULSE, 16'd3);
    send_word(trm_tb_pkg::CMD_PULSE, 16'd1000);
    send_word(trm_tb_pkg::CMD_WINDOW_END, 16'h0000);
    wait_results();

    // Random windows of random length and spread
    while (sent_pulses + sent_closes < N_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) n_pulses = 0;
      else if (pick < 80) n_pulses = $urandom_range(1, 6);
      else n_pulses = $urandom_range(7, 20);
      pick = $urandom_range(99);
      if (pick < 8) spread = SPREAD_ZERO_ONE;
      else if (pick < 35) spread = SPREAD_SMALL;
      else if (pick < 60) spread = SPREAD_MID;
      else if (pick < 78) spread = SPREAD_FULL;
      else if (pick < 86) spread = SPREAD_TOP;
      else spread = SPREAD_MIXED;
      send_window(n_pulses, spread);
      if (!paused && sent_pulses + sent_closes >= N_ITEMS / 2) begin
        wait_results();
        paused = 1'b1;
      end
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pulse words and %0d window closes; %0d speed results compared.",
             sent_pulses, sent_closes, checked_cnt);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== tacho_interval_rpm_meter_top.f =====
src/trm_pkg.sv
src/trm_div.sv
src/trm_dp.sv
src/trm_ctrl.sv
src/tacho_interval_rpm_meter_top.sv
tb/trm_tb_pkg.sv
tb/rpm_window_checker.sv
tb/tb_top.sv
